/* hw/rtl/ghl_pkg.sv */
// grid histogram localizer: shared widths, codes, register resets and helpers
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package ghl_pkg;

  // field widths fixed by the block's interface
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 40;
  localparam int MapW     = 40;
  localparam int BoundW   = 10;
  localparam int WeightW  = 16;
  localparam int ReadingW = 10;
  localparam int OpW      = 2;
  localparam int ClassW   = 2;
  localparam int OutRowW  = 2;
  localparam int OutColW  = 3;
  localparam int CellW    = 6;

  // Q0.16 weights: products are rounded half up and shifted down by 16
  localparam int MulFracBits = 16;
  localparam int RoundHalf   = 32768;

  // register reset values
  localparam logic [MapW-1:0]    MapColorsRst  = '0;
  localparam logic [BoundW-1:0]  BoundBlackRst = 10'd30;
  localparam logic [BoundW-1:0]  BoundGreenRst = 10'd80;
  localparam logic [BoundW-1:0]  BoundRedRst   = 10'd140;
  localparam logic [WeightW-1:0] WeightHitRst  = 16'd52429;
  localparam logic [WeightW-1:0] WeightMissRst = 16'd13107;
  localparam logic [WeightW-1:0] MoveExactRst  = 16'd58982;
  localparam logic [WeightW-1:0] MoveOverRst   = 16'd6554;

  typedef enum logic [OpW-1:0] {
    OP_INIT  = 2'd0,
    OP_SENSE = 2'd1,
    OP_MOVE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [ClassW-1:0] {
    CLS_BLACK = 2'd0,
    CLS_GREEN = 2'd1,
    CLS_RED   = 2'd2,
    CLS_WHITE = 2'd3
  } class_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_COLORS  = 3'd0,
    REG_BOUND_BLACK = 3'd1,
    REG_BOUND_GREEN = 3'd2,
    REG_BOUND_RED   = 3'd3,
    REG_WEIGHT_HIT  = 3'd4,
    REG_WEIGHT_MISS = 3'd5,
    REG_MOVE_EXACT  = 3'd6,
    REG_MOVE_OVER   = 3'd7
  } cfg_reg_e;

  // map color of one cell; cells past the end of the map read as class zero
  function automatic logic [ClassW-1:0] map_class(input logic [MapW-1:0] map,
                                                  input logic [CellW-1:0] cell_idx);
    logic [MapW-1:0] shifted;
    shifted = map >> {cell_idx, 1'b0};
    return shifted[ClassW-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ghl_if.sv */
// grid histogram localizer: valid/ready channel interfaces (input, result, config)
// depends on ghl_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ghl_in_if;
  logic                         valid;
  logic                         ready;
  logic [ghl_pkg::OpW-1:0]      opcode;
  logic [ghl_pkg::ReadingW-1:0] reading;

  modport source (output valid, output opcode, output reading, input ready);
  modport sink   (input valid, input opcode, input reading, output ready);
endinterface

interface ghl_out_if #(
  parameter int ProbW = 17
);
  logic                        valid;
  logic                        ready;
  logic [ghl_pkg::OutRowW-1:0] row;
  logic [ghl_pkg::OutColW-1:0] column;
  logic [ProbW-1:0]            probability;
  logic [ghl_pkg::ClassW-1:0]  color_class;
  logic                        all_zero;
  logic                        last;

  modport source (output valid, output row, output column, output probability,
                  output color_class, output all_zero, output last, input ready);
  modport sink   (input valid, input row, input column, input probability,
                  input color_class, input all_zero, input last, output ready);
endinterface

interface ghl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ghl_pkg::CfgIdxW-1:0]  index;
  logic [ghl_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ghl_mem.sv */
// grid histogram localizer: belief store, one write and one registered read port
// per-entry valid bits make unwritten or cleared entries read the uniform value
`timescale 1ns / 1ps
`default_nettype none

module ghl_mem #(
  parameter int               Depth    = 20,
  parameter int               Width    = 18,
  parameter int               AddrW    = 5,
  parameter logic [Width-1:0] ResetVal = '0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rdata_q;

  // valid bits: reset and clear bring back the uniform belief
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : ResetVal;
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/ghl_div.sv */
// grid histogram localizer: restoring divider, one quotient bit per cycle
// standalone; the caller guarantees the quotient fits in QW bits
`timescale 1ns / 1ps
`default_nettype none

module ghl_div #(
  parameter int SumW = 23,
  parameter int QW   = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SumW+QW-1:0]   dividend_i,
  input  logic [SumW-1:0]      divisor_i,
  output logic                 done_o,
  output logic [QW-1:0]        quot_o
);

  localparam int CntW = $clog2(QW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] rem_q;
  logic [SumW-1:0] dsr_q;
  logic [QW-1:0]   dvd_q;
  logic [QW-1:0]   quot_q;

  logic [SumW:0]   trial;
  logic [SumW:0]   diff;
  logic            fits;

  // one trial subtraction per cycle
  assign trial = {rem_q, dvd_q[QW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  // iteration count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder, dividend bits and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[SumW+QW-1:QW];
      dvd_q <= dividend_i[QW-1:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[SumW-1:0] : trial[SumW-1:0];
      dvd_q  <= {dvd_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* hw/rtl/grid_histogram_localizer_top.sv */
// grid histogram localizer: top level with sequencer, shared multiplier and config
// depends on ghl_pkg, ghl_if, ghl_mem and ghl_div
`timescale 1ns / 1ps
`default_nettype none

// Discrete Bayes localizer over a GRID_ROWS x GRID_COLS grid. Each input beat
// (opcode, reading) updates the belief, opcode 3 leaving it as it is, and is
// answered by one result beat per cell in row-major order, the final one flagged
// by last; no new input is taken until that final beat is out. One multiplier
// walks the cells for the move and sense products and a bit-serial divider
// renormalizes each cell; the result side can stall the output beats.
// Configuration writes are always taken and must only be issued while no item
// is in flight.

module grid_histogram_localizer_top #(
  parameter int GRID_ROWS      = 4,
  parameter int GRID_COLS      = 5,
  parameter int PROB_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ghl_in_if.sink     in_i,
  ghl_out_if.source  out_o,
  ghl_cfg_if.sink    cfg_i
);

  localparam int Ncells  = GRID_ROWS * GRID_COLS;
  localparam int IdxW    = $clog2(Ncells);
  localparam int RowCntW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int ColCntW = $clog2(GRID_COLS);
  localparam int BW      = PROB_FRAC_BITS + 2;
  localparam int PW      = PROB_FRAC_BITS + 1;
  localparam int WW      = ghl_pkg::WeightW;
  localparam int PrW     = BW + WW;
  localparam int AccW    = BW + WW + 1;
  localparam int SumW    = BW + $clog2(Ncells);
  localparam int DivW    = SumW + PW;
  localparam int RowOW   = ghl_pkg::OutRowW;
  localparam int ColOW   = ghl_pkg::OutColW;
  localparam int CellW   = ghl_pkg::CellW;
  localparam int FracW   = ghl_pkg::MulFracBits;
  localparam int OneInt  = 1 << PROB_FRAC_BITS;
  localparam int UniInt  = (OneInt + Ncells / 2) / Ncells;
  localparam logic [BW-1:0] UniVal = BW'(UniInt);
  localparam logic [PW-1:0] OneVal = PW'(OneInt);

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001,
    S_RD    = 12'h002,
    S_M1    = 12'h004,
    S_M2    = 12'h008,
    S_WR    = 12'h010,
    S_NCHK  = 12'h020,
    S_NRD   = 12'h040,
    S_NLD   = 12'h080,
    S_NDIV  = 12'h100,
    S_ORD   = 12'h200,
    S_OLD   = 12'h400,
    S_OWAIT = 12'h800
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [ghl_pkg::MapW-1:0]    map_q;
  logic [ghl_pkg::BoundW-1:0]  bound_black_q, bound_green_q, bound_red_q;
  logic [WW-1:0]               weight_hit_q, weight_miss_q, move_exact_q, move_over_q;

  // sequencer state
  logic [IdxW-1:0]     idx_q;
  logic [RowCntW-1:0]  row_q;
  logic [ColCntW-1:0]  col_q;
  logic                shift_q;
  logic                zero_q;
  ghl_pkg::class_e     cls_q;
  ghl_pkg::class_e     cls;

  // datapath registers
  logic [BW-1:0]       h1_q, h2_q, cur_q;
  logic [AccW-1:0]     acc_q;
  logic [SumW-1:0]     sum_q;

  // result beat registers
  logic [RowOW-1:0]    out_row_q;
  logic [ColOW-1:0]    out_col_q;
  logic [PW-1:0]       out_prob_q;
  logic [ghl_pkg::ClassW-1:0] out_cls_q;
  logic                out_zero_q;
  logic                out_last_q;

  logic                in_acc, out_acc, cfg_acc;
  logic                last_cell, col_end, adv, norm_end;
  logic                mem_we, mem_clear;
  logic [BW-1:0]       mem_wdata, mem_rdata;
  logic                div_start, div_done;
  logic [PW-1:0]       div_quot, norm_val;
  logic [DivW-1:0]     div_dividend;
  logic [BW-1:0]       mul_a;
  logic [WW-1:0]       mul_b, sense_w;
  logic [PrW-1:0]      prod;
  logic [AccW-1:0]     rnd_sum;
  logic [BW-1:0]       rnd_val;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign last_cell = (idx_q == IdxW'(Ncells - 1));
  assign col_end   = (col_q == ColCntW'(GRID_COLS - 1));

  // reading class, bounds tested in order so the lowest match wins
  always_comb begin
    if (in_i.reading <= bound_black_q) begin
      cls = ghl_pkg::CLS_BLACK;
    end else if (in_i.reading <= bound_green_q) begin
      cls = ghl_pkg::CLS_GREEN;
    end else if (in_i.reading <= bound_red_q) begin
      cls = ghl_pkg::CLS_RED;
    end else begin
      cls = ghl_pkg::CLS_WHITE;
    end
  end

  // shared multiplier and rounding
  assign sense_w = (ghl_pkg::map_class(map_q, CellW'(idx_q)) == cls_q) ?
                   weight_hit_q : weight_miss_q;
  assign prod    = mul_a * mul_b;
  assign rnd_sum = (acc_q + AccW'(ghl_pkg::RoundHalf)) >> FracW;
  assign rnd_val = BW'(rnd_sum);

  // normalize: cell * one + sum/2, over the sum, clamped to one
  assign div_dividend = DivW'({mem_rdata, {PROB_FRAC_BITS{1'b0}}}) + DivW'(sum_q >> 1);
  assign norm_val     = (div_quot > OneVal) ? OneVal : div_quot;

  // sequencer
  always_comb begin
    state_d   = state_q;
    adv       = 1'b0;
    norm_end  = 1'b0;
    mem_we    = 1'b0;
    mem_clear = 1'b0;
    mem_wdata = rnd_val;
    div_start = 1'b0;
    mul_a     = mem_rdata;
    mul_b     = sense_w;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (ghl_pkg::op_e'(in_i.opcode))
            ghl_pkg::OP_INIT: begin
              mem_clear = 1'b1;
              state_d   = S_ORD;
            end
            ghl_pkg::OP_SENSE, ghl_pkg::OP_MOVE: state_d = S_RD;
            default: state_d = S_ORD;
          endcase
        end
      end
      S_RD: state_d = S_M1;
      S_M1: begin
        if (shift_q) begin
          mul_a   = h1_q;
          mul_b   = move_exact_q;
          state_d = S_M2;
        end else begin
          state_d = S_WR;
        end
      end
      S_M2: begin
        mul_a   = h2_q;
        mul_b   = move_over_q;
        state_d = S_WR;
      end
      S_WR: begin
        mem_we  = 1'b1;
        adv     = 1'b1;
        state_d = last_cell ? S_NCHK : S_RD;
      end
      S_NCHK: begin
        if (sum_q == '0) begin
          norm_end = 1'b1;
        end else begin
          state_d = S_NRD;
        end
      end
      S_NRD: state_d = S_NLD;
      S_NLD: begin
        div_start = 1'b1;
        state_d   = S_NDIV;
      end
      S_NDIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = BW'(norm_val);
          adv       = 1'b1;
          if (last_cell) begin
            norm_end = 1'b1;
          end else begin
            state_d = S_NRD;
          end
        end
      end
      S_ORD: state_d = S_OLD;
      S_OLD: state_d = S_OWAIT;
      S_OWAIT: begin
        if (out_acc) begin
          adv     = 1'b1;
          state_d = last_cell ? S_IDLE : S_ORD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // after a normalization the move pass hands over to the sense pass
    if (norm_end) begin
      state_d = shift_q ? S_RD : S_ORD;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      shift_q <= 1'b0;
      zero_q  <= 1'b0;
      cls_q   <= ghl_pkg::CLS_BLACK;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cls_q   <= cls;
        zero_q  <= 1'b0;
        shift_q <= (ghl_pkg::op_e'(in_i.opcode) == ghl_pkg::OP_MOVE);
      end
      if (state_q == S_NCHK && sum_q == '0) begin
        zero_q <= 1'b1;
      end
      if (norm_end) begin
        shift_q <= 1'b0;
      end
      // cell walk in row-major order
      if (adv) begin
        if (last_cell) begin
          idx_q <= '0;
          row_q <= '0;
          col_q <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
          if (col_end) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_M1) begin
      cur_q <= mem_rdata;
      acc_q <= (shift_q && col_q == '0) ? '0 : AccW'(prod);
    end
    if (state_q == S_M2) begin
      acc_q <= acc_q + ((col_q >= ColCntW'(2)) ? AccW'(prod) : '0);
    end
    if (state_q == S_WR) begin
      h2_q  <= h1_q;
      h1_q  <= cur_q;
      sum_q <= sum_q + SumW'(rnd_val);
    end
    if (in_acc || norm_end) begin
      sum_q <= '0;
    end
    if (state_q == S_OLD) begin
      out_row_q  <= RowOW'(row_q);
      out_col_q  <= ColOW'(col_q);
      out_prob_q <= mem_rdata[PW-1:0];
      out_cls_q  <= cls_q;
      out_zero_q <= zero_q;
      out_last_q <= last_cell;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q         <= ghl_pkg::MapColorsRst;
      bound_black_q <= ghl_pkg::BoundBlackRst;
      bound_green_q <= ghl_pkg::BoundGreenRst;
      bound_red_q   <= ghl_pkg::BoundRedRst;
      weight_hit_q  <= ghl_pkg::WeightHitRst;
      weight_miss_q <= ghl_pkg::WeightMissRst;
      move_exact_q  <= ghl_pkg::MoveExactRst;
      move_over_q   <= ghl_pkg::MoveOverRst;
    end else if (cfg_acc) begin
      case (ghl_pkg::cfg_reg_e'(cfg_i.index))
        ghl_pkg::REG_MAP_COLORS:  map_q         <= cfg_i.data[ghl_pkg::MapW-1:0];
        ghl_pkg::REG_BOUND_BLACK: bound_black_q <= cfg_i.data[ghl_pkg::BoundW-1:0];
        ghl_pkg::REG_BOUND_GREEN: bound_green_q <= cfg_i.data[ghl_pkg::BoundW-1:0];
        ghl_pkg::REG_BOUND_RED:   bound_red_q   <= cfg_i.data[ghl_pkg::BoundW-1:0];
        ghl_pkg::REG_WEIGHT_HIT:  weight_hit_q  <= cfg_i.data[WW-1:0];
        ghl_pkg::REG_WEIGHT_MISS: weight_miss_q <= cfg_i.data[WW-1:0];
        ghl_pkg::REG_MOVE_EXACT:  move_exact_q  <= cfg_i.data[WW-1:0];
        ghl_pkg::REG_MOVE_OVER:   move_over_q   <= cfg_i.data[WW-1:0];
        default: ;
      endcase
    end
  end

  // result channel
  assign out_o.valid       = (state_q == S_OWAIT);
  assign out_o.row         = out_row_q;
  assign out_o.column      = out_col_q;
  assign out_o.probability = out_prob_q;
  assign out_o.color_class = out_cls_q;
  assign out_o.all_zero    = out_zero_q;
  assign out_o.last        = out_last_q;

  // belief store
  ghl_mem #(
    .Depth    (Ncells),
    .Width    (BW),
    .AddrW    (IdxW),
    .ResetVal (UniVal)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mem_clear),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // normalizing divider
  ghl_div #(
    .SumW (SumW),
    .QW   (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule

`default_nettype wire

/* hw/rtl/ghl_checker.sv */
// grid histogram localizer: port-level checks over time, bound to the top level
// depends on grid_histogram_localizer_top port names
`timescale 1ns / 1ps
`default_nettype none

module ghl_checker #(
  parameter int GRID_COLS = 5
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_last_i,
  input logic [2:0] out_column_i
);

  // results only while no input is being taken
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
    else $error("result beat offered while input is ready");

  // an accepted beat closes the input until its run is out
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input still ready after accepting a beat");

  // the final result beat reopens the input
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> in_ready_i)
    else $error("input not ready after last result beat");

  // reported column lies inside the grid
  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_column_i < GRID_COLS))
    else $error("result column outside the grid");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_last_i) && $stable(out_column_i)))
    else $error("stalled result beat changed");

endmodule

bind grid_histogram_localizer_top ghl_checker #(
  .GRID_COLS (GRID_COLS)
) u_ghl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_last_i   (out_o.last),
  .out_column_i (out_o.column)
);

`default_nettype wire
